/* hw/rtl/http2_frame_header_checker_top_macros.svh */
// Assertion macros shared by the frame header checker RTL
`ifndef HTTP2_FRAME_HEADER_CHECKER_TOP_MACROS_SVH
`define HTTP2_FRAME_HEADER_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low
`define H2FH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("h2fh assertion failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low
`define H2FH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("h2fh assertion failed");

`endif

/* hw/rtl/h2fh_pkg.sv */
// Types and constants for the HTTP/2 frame header checker
`timescale 1ns / 1ps

package h2fh_pkg;

	localparam int unsigned LEN_W  = 24;
	localparam int unsigned SID_W  = 31;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 4;

	// Header byte positions
	localparam logic [POS_W-1:0] POS_LEN_LAST = 4'd2;
	localparam logic [POS_W-1:0] POS_TYPE     = 4'd3;
	localparam logic [POS_W-1:0] POS_FLAGS    = 4'd4;
	localparam logic [POS_W-1:0] POS_LAST     = 4'd8;

	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 24'd16384;

	// Frame type codes
	localparam logic [7:0] T_DATA          = 8'd0;
	localparam logic [7:0] T_HEADERS       = 8'd1;
	localparam logic [7:0] T_PRIORITY      = 8'd2;
	localparam logic [7:0] T_RST_STREAM    = 8'd3;
	localparam logic [7:0] T_SETTINGS      = 8'd4;
	localparam logic [7:0] T_PUSH_PROMISE  = 8'd5;
	localparam logic [7:0] T_PING          = 8'd6;
	localparam logic [7:0] T_GOAWAY        = 8'd7;
	localparam logic [7:0] T_WINDOW_UPDATE = 8'd8;
	localparam logic [7:0] T_CONTINUATION  = 8'd9;

	// Flag bit positions
	localparam int unsigned FLAG_ACK_BIT    = 0;
	localparam int unsigned FLAG_PADDED_BIT = 3;

	// Fixed and minimum payload lengths
	localparam logic [LEN_W-1:0] PRIORITY_LEN   = 24'd5;
	localparam logic [LEN_W-1:0] RST_STREAM_LEN = 24'd4;
	localparam logic [LEN_W-1:0] PING_LEN       = 24'd8;
	localparam logic [LEN_W-1:0] GOAWAY_MIN     = 24'd8;
	localparam logic [LEN_W-1:0] PUSH_MIN_PAD   = 24'd5;
	localparam logic [LEN_W-1:0] PUSH_MIN       = 24'd4;
	localparam logic [LEN_W-1:0] WINDOW_LEN     = 24'd4;

	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_SIZE  = 2'd1,
		VERDICT_PROTO = 2'd2
	} verdict_t;

	// Gathered header handed from the gatherer to the judge
	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [7:0]        ftype;
		logic [7:0]        flags;
		logic [SID_W-1:0]  sid;
		logic              len_mod6_zero;
	} hdr_t;

	// x mod 6 for x below 256, by reciprocal multiply (171/1024 ~ 1/6)
	function automatic logic [2:0] mod6_small(input logic [7:0] x);
		logic [15:0] prod;
		logic [5:0]  quot;
		logic [8:0]  back;
		logic [7:0]  rem;
		prod = 16'(x) * 16'd171;
		quot = prod[15:10];
		back = 9'(quot) * 9'd6;
		rem  = x - back[7:0];
		return rem[2:0];
	endfunction

	// Running residue: (prev * 256 + b) mod 6, with 256 mod 6 = 4
	function automatic logic [2:0] mod6_step(input logic [2:0] prev, input logic [7:0] b);
		logic [7:0] t;
		t = 8'({prev, 2'b00}) + 8'(mod6_small(b));
		return mod6_small(t);
	endfunction

endpackage

/* hw/rtl/h2fh_ifs.sv */
// Valid/ready channel interfaces for the byte input and the header result
`timescale 1ns / 1ps

interface h2fh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface h2fh_frame_if;
	logic        valid;
	logic        ready;
	logic [23:0] frame_length;
	logic [7:0]  frame_type;
	logic [7:0]  frame_flags;
	logic [30:0] stream_ident;
	logic [1:0]  verdict;

	modport source (output valid, output frame_length, output frame_type,
		output frame_flags, output stream_ident, output verdict, input ready);
	modport sink   (input valid, input frame_length, input frame_type,
		input frame_flags, input stream_ident, input verdict, output ready);
endinterface

/* hw/rtl/h2fh_gather.sv */
// Header byte gatherer and payload byte counter
`timescale 1ns / 1ps
`include "http2_frame_header_checker_top_macros.svh"

module h2fh_gather import h2fh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [BYTE_W-1:0] data_byte,
	output hdr_t              hdr,
	output logic              done
);

	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic [2:0]        mod6_q;
	logic [7:0]        type_q;
	logic [7:0]        flags_q;
	logic [SID_W-1:0]  sid_q;
	logic [LEN_W-1:0]  left_q;
	logic              in_payload;

	assign in_payload = (left_q != '0);

	// Flag the last header byte; the stream id completes with this byte
	assign done              = !in_payload && (pos_q == POS_LAST);
	assign hdr.length        = len_q;
	assign hdr.ftype         = type_q;
	assign hdr.flags         = flags_q;
	assign hdr.sid           = {sid_q[SID_W-9:0], data_byte};
	assign hdr.len_mod6_zero = (mod6_q == 3'd0);

	// Advance header position, shift fields in, count off payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			mod6_q  <= '0;
			type_q  <= '0;
			flags_q <= '0;
			sid_q   <= '0;
			left_q  <= '0;
		end else if (en) begin
			if (in_payload) begin
				left_q <= left_q - 24'd1;
			end else if (pos_q == POS_LAST) begin
				left_q <= len_q;
				pos_q  <= '0;
				len_q  <= '0;
				mod6_q <= '0;
				sid_q  <= '0;
			end else begin
				pos_q <= pos_q + 4'd1;
				if (pos_q <= POS_LEN_LAST) begin
					len_q  <= {len_q[LEN_W-9:0], data_byte};
					mod6_q <= mod6_step(mod6_q, data_byte);
				end else if (pos_q == POS_TYPE) begin
					type_q <= data_byte;
				end else if (pos_q == POS_FLAGS) begin
					flags_q <= data_byte;
				end else begin
					sid_q <= {sid_q[SID_W-9:0], data_byte};
				end
			end
		end
	end

	`H2FH_ASSERT_SAME(a_pos_range, 1'b1, pos_q <= POS_LAST)
	`H2FH_ASSERT_SAME(a_payload_pos, in_payload, pos_q == '0)
	`H2FH_ASSERT_NEXT(a_load_left, en && done, left_q == $past(len_q) && pos_q == '0)

endmodule

/* hw/rtl/h2fh_judge.sv */
// Verdict logic for one gathered frame header
`timescale 1ns / 1ps

module h2fh_judge import h2fh_pkg::*; (
	input  hdr_t             hdr,
	input  logic [LEN_W-1:0] frame_limit,
	output verdict_t         verdict
);

	logic sid_zero;
	logic len_zero;
	logic flag_ack;
	logic flag_pad;

	assign sid_zero = (hdr.sid == '0);
	assign len_zero = (hdr.length == '0);
	assign flag_ack = hdr.flags[FLAG_ACK_BIT];
	assign flag_pad = hdr.flags[FLAG_PADDED_BIT];

	// Check size limit first, then the per-type rules
	always_comb begin
		verdict = VERDICT_OK;
		if (hdr.length > frame_limit) begin
			verdict = VERDICT_SIZE;
		end else begin
			unique case (hdr.ftype)
				T_DATA, T_HEADERS, T_CONTINUATION: begin
					if (sid_zero) verdict = VERDICT_PROTO;
				end
				T_PRIORITY: begin
					if (sid_zero) verdict = VERDICT_PROTO;
					else if (hdr.length != PRIORITY_LEN) verdict = VERDICT_SIZE;
				end
				T_RST_STREAM: begin
					if (sid_zero) verdict = VERDICT_PROTO;
					else if (hdr.length != RST_STREAM_LEN) verdict = VERDICT_SIZE;
				end
				T_SETTINGS: begin
					if (!sid_zero) verdict = VERDICT_PROTO;
					else if (flag_ack && !len_zero) verdict = VERDICT_SIZE;
					else if (!hdr.len_mod6_zero) verdict = VERDICT_SIZE;
				end
				T_PUSH_PROMISE: begin
					if (sid_zero) verdict = VERDICT_PROTO;
					else if (hdr.length < (flag_pad ? PUSH_MIN_PAD : PUSH_MIN))
						verdict = VERDICT_SIZE;
				end
				T_PING: begin
					if (!sid_zero) verdict = VERDICT_PROTO;
					else if (hdr.length != PING_LEN) verdict = VERDICT_SIZE;
				end
				T_GOAWAY: begin
					if (!sid_zero) verdict = VERDICT_PROTO;
					else if (hdr.length < GOAWAY_MIN) verdict = VERDICT_SIZE;
				end
				T_WINDOW_UPDATE: begin
					if (hdr.length != WINDOW_LEN) verdict = VERDICT_SIZE;
				end
				default: begin
					verdict = VERDICT_OK;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/http2_frame_header_checker_top.sv */
// Top level of the HTTP/2 frame header checker
//
// byte_in carries the received HTTP/2 stream, one data_byte per word.
// frame_out carries one word per frame header: length, type, flags,
// stream id (reserved bit cleared) and a verdict (ok, frame size error,
// protocol error). Payload bytes are counted off and produce no word.
// cfg_wr_en/cfg_wr_data write the frame size limit; write it only while idle.
// Throughput: one byte per cycle. The byte path is an input register,
// the gather/judge logic and a result register; a header word is loaded
// into the result register as the ninth header byte leaves the input
// register, and frame_out is driven from that result register.
// A stalled frame_out holds its word; bytes keep flowing until the next
// ninth header byte meets a full result register, and then byte_in.ready
// drops until the word is taken.
// Reset clears the header position and payload count (the next byte is a
// header's first), empties both registers and sets the frame size limit
// to 16384.
`timescale 1ns / 1ps
`include "http2_frame_header_checker_top_macros.svh"

module http2_frame_header_checker_top import h2fh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LEN_W-1:0]   cfg_wr_data,
	h2fh_byte_if.sink          byte_in,
	h2fh_frame_if.source       frame_out
);

	logic [LEN_W-1:0]  max_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              s1_adv;
	logic              out_free;
	logic              out_valid_q;
	hdr_t              hdr;
	logic              hdr_done;
	verdict_t          verdict;
	hdr_t              hdr_q;
	verdict_t          verdict_q;

	// Hold the configured maximum frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_FRAME_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// Advance the input register unless a header word finds the output full
	assign out_free      = !out_valid_q || frame_out.ready;
	assign s1_adv        = valid_s1 && (!hdr_done || out_free);
	assign byte_in.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	h2fh_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (s1_adv),
		.data_byte (byte_s1),
		.hdr       (hdr),
		.done      (hdr_done)
	);

	h2fh_judge u_judge (
		.hdr         (hdr),
		.frame_limit (max_q),
		.verdict     (verdict)
	);

	// Load the result register on a finished header, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && hdr_done) begin
			out_valid_q <= 1'b1;
		end else if (frame_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && hdr_done) begin
			hdr_q     <= hdr;
			verdict_q <= verdict;
		end
	end

	assign frame_out.valid        = out_valid_q;
	assign frame_out.frame_length = hdr_q.length;
	assign frame_out.frame_type   = hdr_q.ftype;
	assign frame_out.frame_flags  = hdr_q.flags;
	assign frame_out.stream_ident = hdr_q.sid;
	assign frame_out.verdict      = verdict_q;

	`H2FH_ASSERT_NEXT(a_word_loaded, s1_adv && hdr_done, out_valid_q)
	`H2FH_ASSERT_SAME(a_no_overwrite, out_valid_q && !frame_out.ready, !(s1_adv && hdr_done))
	`H2FH_ASSERT_NEXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(byte_s1))

endmodule
